FILE: hw/rtl/wssr_pkg.sv
// Shared types, constants and register codes for the window speckle restoration block.
// No dependencies.
package wssr_pkg;

  localparam int MaxWindowSamples = 256;
  localparam int CntW = $clog2(MaxWindowSamples + 1);

  typedef struct packed {
    logic               sample_valid;
    logic [23:0]        diag_one;
    logic [23:0]        diag_two;
    logic [23:0]        diag_three;
    logic [23:0]        diag_four;
    logic signed [31:0] elem_value;
    logic signed [31:0] prior_value;
    logic               is_centre;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] restored_value;
    logic               empty_window;
  } out_item_t;

  // Window totals handed from the accumulator to the back end.
  typedef struct packed {
    logic [CntW-1:0]    count;
    logic [3:0][31:0]   isum;
    logic [3:0][55:0]   ssum;
    logic signed [39:0] psum;
    logic signed [31:0] centre;
  } win_t;

  localparam logic [1:0] RegLooks = 2'd0;
  localparam logic [1:0] RegChans = 2'd1;
  localparam logic [1:0] RegEps   = 2'd2;

  typedef enum logic [3:0] {
    BkIdle, BkMean, BkSq, BkRatio, BkRwait, BkAcc, BkCoef, BkCwait,
    BkNum, BkSum, BkDiv, BkDwait, BkOut
  } bk_state_t;

endpackage

FILE: hw/rtl/wssr_divider.sv
// Shared restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
// Does not depend on wssr_pkg (no imports needed).
module wssr_divider (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [127:0] dividend,
  input  logic [63:0]  divisor,
  output logic         done,
  output logic [127:0] quotient
);
  logic [127:0] q_r, q_nxt;
  logic [64:0]  r_r, r_nxt;
  logic [63:0]  d_r;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         run_r, run_nxt, done_r, done_nxt;
  logic [64:0]  sh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; cnt_nxt = cnt_r; run_nxt = run_r; done_nxt = 1'b0;
    sh = {r_r[63:0], q_r[127]};
    if (go) begin
      q_nxt = dividend; r_nxt = '0; cnt_nxt = 8'd128; run_nxt = 1'b1;
    end else if (run_r) begin
      q_nxt = {q_r[126:0], 1'b0};
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end else begin
        r_nxt = sh;
      end
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt;
    if (go) d_r <= divisor;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

FILE: hw/rtl/wssr_front.sv
// Front end: accumulates window samples, hands finished windows to a one-deep queue.
// Depends on wssr_pkg.
module wssr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  wssr_pkg::in_item_t in_item,
  input  logic             q_pop,
  output logic             q_full,
  output wssr_pkg::win_t   q_win
);
  import wssr_pkg::*;

  win_t acc_r, acc_nxt;
  win_t q_r;
  logic full_r;
  logic [47:0] sq [4];
  logic [23:0] d [4];

  always_comb begin
    d[0] = in_item.diag_one; d[1] = in_item.diag_two;
    d[2] = in_item.diag_three; d[3] = in_item.diag_four;
    for (int c = 0; c < 4; c++) sq[c] = d[c] * d[c];
    acc_nxt = acc_r;
    if (in_item.sample_valid && acc_r.count < CntW'(MaxWindowSamples)) begin
      acc_nxt.count = acc_r.count + CntW'(1);
      for (int c = 0; c < 4; c++) begin
        acc_nxt.isum[c] = acc_r.isum[c] + {8'd0, d[c]};
        acc_nxt.ssum[c] = acc_r.ssum[c] + {8'd0, sq[c]};
      end
      acc_nxt.psum = acc_r.psum + 40'(in_item.prior_value);
    end
    if (in_item.is_centre)
      acc_nxt.centre = in_item.sample_valid ? in_item.elem_value : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; full_r <= 1'b0;
    end else begin
      full_r <= (in_take && in_item.last_sample) || (full_r && !q_pop);
      if (in_take) begin
        if (in_item.last_sample) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_nxt;
        end
      end
    end
    if (in_take && in_item.last_sample) q_r <= acc_nxt;
  end

  assign q_full = full_r;
  assign q_win = q_r;
endmodule

FILE: hw/rtl/wssr_back.sv
// Back end: coefficient and restored value for one window, through a shared divider.
// Depends on wssr_pkg and wssr_divider.
module wssr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_full,
  input  wssr_pkg::win_t   q_win,
  input  logic [6:0]       looks,
  input  logic [2:0]       chans,
  input  logic [15:0]      eps,
  output logic             q_pop,
  output logic             out_valid,
  output wssr_pkg::out_item_t out_item
);
  import wssr_pkg::*;

  bk_state_t st_r, st_nxt;
  win_t w_r;
  logic [1:0]  ch_r, ch_nxt;
  logic [63:0] m2_r;
  logic [34:0] tot_r;
  logic [31:0] coef_r;
  logic [71:0] pm_r;
  logic [127:0] num_r;
  logic        neg_r;
  logic [63:0] div_r;
  logic        go;
  logic [127:0] dvd;
  logic [63:0] dvs;
  logic        done;
  logic [127:0] quo;
  logic [2:0]  nch;
  logic [6:0]  lk;
  logic [63:0] var_c, den_c;
  logic        ovalid_r;
  out_item_t   oitem_r;
  logic [39:0] pmag;

  wssr_divider u_div (.clk, .rst_n, .go, .dividend(dvd), .divisor(dvs),
    .done, .quotient(quo));

  always_comb begin
    nch = (chans < 3'd2) ? 3'd2 : ((chans > 3'd4) ? 3'd4 : chans);
    lk = (looks == 7'd0) ? 7'd1 : looks;
    // mean of squares is on the divider output in BkRatio
    var_c = (quo[63:0] > m2_r) ? quo[63:0] - m2_r : '0;
    den_c = var_c + {32'd0, eps, 16'd0};
    pmag = w_r.psum[39] ? 40'(-w_r.psum) : w_r.psum;
    st_nxt = st_r; ch_nxt = ch_r; go = 1'b0; dvd = '0; dvs = 64'd1; q_pop = 1'b0;
    unique case (st_r)
      BkIdle: if (q_full) st_nxt = (q_win.count == '0) ? BkIdle : BkMean;
      BkMean: begin
        go = 1'b1; dvd = {96'd0, w_r.isum[ch_r]}; dvs = 64'(w_r.count);
        st_nxt = BkSq;
      end
      BkSq: if (done) begin
        go = 1'b1; dvd = {72'd0, w_r.ssum[ch_r]}; dvs = 64'(w_r.count);
        st_nxt = BkRatio;
      end
      BkRatio: if (done) begin
        if (den_c == '0) st_nxt = BkAcc;
        else begin
          go = 1'b1; dvd = {48'd0, m2_r, 16'd0}; dvs = den_c; st_nxt = BkRwait;
        end
      end
      BkRwait: if (done) st_nxt = BkAcc;
      BkAcc: begin
        if (3'({1'b0, ch_r}) + 3'd1 == nch) begin
          ch_nxt = '0; st_nxt = BkCoef;
        end else begin
          ch_nxt = ch_r + 2'd1; st_nxt = BkMean;
        end
      end
      BkCoef: begin
        go = 1'b1; dvd = {93'd0, tot_r}; dvs = 64'(nch) * 64'(lk); st_nxt = BkCwait;
      end
      BkCwait: if (done) st_nxt = BkNum;
      BkNum: st_nxt = BkSum;
      BkSum: st_nxt = BkDiv;
      BkDiv: begin
        go = 1'b1; dvd = num_r[127] ? -num_r : num_r; dvs = div_r; st_nxt = BkDwait;
      end
      BkDwait: if (done) st_nxt = BkOut;
      BkOut: st_nxt = BkIdle;
      default: st_nxt = BkIdle;
    endcase
    if (st_r == BkIdle && q_full) q_pop = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BkIdle; ch_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ch_r <= ch_nxt;
      ovalid_r <= (st_r == BkIdle && q_full && q_win.count == '0) || (st_r == BkOut);
    end
    if (q_pop) begin
      w_r <= q_win; tot_r <= '0;
      oitem_r <= '{restored_value: '0, empty_window: 1'b1};
    end
    if (st_r == BkSq && done) m2_r <= quo[31:0] * quo[31:0];
    if (st_r == BkRatio && done && den_c == '0) tot_r <= tot_r + 35'hFFFF_FFFF;
    if (st_r == BkRwait && done)
      tot_r <= tot_r + ((quo > 128'hFFFF_FFFF) ? 35'hFFFF_FFFF : 35'(quo[31:0]));
    if (st_r == BkCwait && done) coef_r <= quo[31:0];
    if (st_r == BkNum) begin
      pm_r <= pmag * coef_r;
      div_r <= 64'd65536 + 64'(w_r.count) * 64'(coef_r);
    end
    if (st_r == BkSum)
      num_r <= 128'($signed({w_r.centre, 16'd0})) +
               (w_r.psum[39] ? -128'(pm_r) : 128'(pm_r));
    if (st_r == BkDiv) neg_r <= num_r[127];
    if (st_r == BkDwait && done) begin
      oitem_r.empty_window <= 1'b0;
      if (neg_r)
        oitem_r.restored_value <= (quo > 128'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
      else
        oitem_r.restored_value <= (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    end
  end

  // The divider gets the magnitude of the numerator at go; the sign is kept in neg_r.
  assign out_valid = ovalid_r;
  assign out_item = oitem_r;
endmodule

FILE: hw/rtl/window_stat_speckle_restoration.sv
// Top level of the window speckle restoration block: APB registers, front and back ends.
// Depends on wssr_pkg, wssr_front, wssr_back, wssr_divider.
//
// Usage:
//  - Input: drive in_item and pulse in_start while in_busy is low; one sample per
//    transaction, one per cycle. The sample marked last closes the window.
//  - Output: out_valid strobes for one cycle with out_item; cannot be held off.
//  - A window goes into a one-deep queue; the back end runs per active channel
//    three divisions (mean, mean of squares, ratio), skipping the ratio when
//    variance plus eps is zero, then the coefficient and final division.
//  - in_busy rises only when a finished window is queued and the back end is busy;
//    the front keeps taking the next window's samples until that window closes.
//  - Empty windows give a zero result with empty_window set, strobed through the queue
//    register and then the output register when the back end is idle.
//  - Reset (rst_n low, synchronous) clears the accumulators and registers to
//    looks 1, three channels, eps 1.
//  - Registers: looks at 0x0, diag_channels at 0x4, variance_eps at 0x8.
module window_stat_speckle_restoration (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  output logic in_busy,
  input  wssr_pkg::in_item_t in_item,
  output logic out_valid,
  output wssr_pkg::out_item_t out_item,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import wssr_pkg::*;

  logic [6:0] looks_r;
  logic [2:0] chans_r;
  logic [15:0] eps_r;
  logic q_full, q_pop, take;
  win_t q_win;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looks_r <= 7'd1; chans_r <= 3'd3; eps_r <= 16'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        RegLooks: looks_r <= cfg_pwdata[6:0];
        RegChans: chans_r <= cfg_pwdata[2:0];
        RegEps:   eps_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[3:2])
      RegLooks: cfg_prdata = {25'd0, looks_r};
      RegChans: cfg_prdata = {29'd0, chans_r};
      RegEps:   cfg_prdata = {16'd0, eps_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // Busy only while a closed window waits and the back end cannot pop it.
  assign in_busy = q_full && !q_pop;
  assign take = in_start && !in_busy;

  wssr_front u_front (.clk, .rst_n, .in_take(take), .in_item, .q_pop, .q_full, .q_win);
  wssr_back u_back (.clk, .rst_n, .q_full, .q_win, .looks(looks_r), .chans(chans_r),
    .eps(eps_r), .q_pop, .out_valid, .out_item);
endmodule
